>>> src/sts_pkg.sv
// Shared types and codes for the sorted table block.
// No dependencies.
package sts_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int KEY_W   = 32;
    localparam int IDX_W   = 6;
    localparam int OCNT_W  = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [KEY_W-1:0] key_value;
        logic [IDX_W-1:0]        read_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [IDX_W-1:0]        position;
        logic signed [KEY_W-1:0] entry_value;
        logic [OCNT_W-1:0]       entry_count;
    } out_word_t;

    typedef struct packed {
        logic we;
        logic re;
    } ram_ctl_t;

endpackage

>>> src/sts_ram.sv
// Single-port-write, single-read table memory, registered read data.
// Depends on sts_pkg.
module sts_ram #(
    parameter int DEPTH = sts_pkg::DEFAULT_CAPACITY,
    parameter int AW    = $clog2(sts_pkg::DEFAULT_CAPACITY)
) (
    input  logic                              aclk,
    input  sts_pkg::ram_ctl_t                 ctl,
    input  logic [AW-1:0]                     waddr,
    input  logic signed [sts_pkg::KEY_W-1:0]  wdata,
    input  logic [AW-1:0]                     raddr,
    output logic signed [sts_pkg::KEY_W-1:0]  rdata
);
    import sts_pkg::*;

    logic signed [KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[waddr] <= wdata;
        end
        if (ctl.re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/sts_engine.sv
// Sequencer for search, shift-insert, shift-remove and read on the table memory.
// Depends on sts_pkg and sts_ram.
module sts_engine #(
    parameter int CAPACITY = sts_pkg::DEFAULT_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sts_pkg::in_word_t   s_data,
    output logic                res_valid,
    input  logic                res_take,
    output sts_pkg::out_word_t  res_data
);
    import sts_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SW    = AW + 2;
    localparam int XW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SRD  = 9'b000000010,
        S_SCMP = 9'b000000100,
        S_DRD  = 9'b000001000,
        S_DWR  = 9'b000010000,
        S_IRD  = 9'b000100000,
        S_ICMP = 9'b001000000,
        S_RDAT = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [SW-1:0]    l_reg, l_next, r_reg, r_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    out_word_t               res_reg, res_next;

    ram_ctl_t                ram_ctl;
    logic [AW-1:0]           waddr, raddr;
    logic signed [KEY_W-1:0] wdata, rdata;

    logic [SW-1:0]           sum_w, mid_w;
    logic [CNT_W:0]          i_plus_w;

    sts_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
        .aclk  (aclk),
        .ctl   (ram_ctl),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sum_w     = SW'(l_reg + r_reg);
    assign mid_w     = sum_w >> 1;
    assign i_plus_w  = {1'b0, i_reg} + 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_data  = res_reg;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        count_next = count_reg;
        res_next   = res_reg;
        ram_ctl    = '0;
        waddr      = AW'(i_reg);
        raddr      = AW'(mid_w);
        wdata      = key_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next  = s_data.operation;
                    key_next = s_data.key_value;
                    res_next = '0;
                    res_next.status      = ST_OK;
                    res_next.entry_count = OCNT_W'(count_reg);
                    case (s_data.operation)
                        OP_INSERT: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                res_next.status = ST_FULL;
                                state_next      = S_DONE;
                            end else begin
                                i_next     = count_reg;
                                state_next = S_IRD;
                            end
                        end
                        OP_REMOVE, OP_LOOKUP: begin
                            l_next     = '0;
                            r_next     = SW'(count_reg) - 1'b1;
                            state_next = S_SRD;
                        end
                        default: begin
                            if (XW'(s_data.read_index) >= XW'(count_reg)) begin
                                res_next.status = ST_RANGE;
                                state_next      = S_DONE;
                            end else begin
                                ram_ctl.re = 1'b1;
                                raddr      = AW'(s_data.read_index);
                                state_next = S_RDAT;
                            end
                        end
                    endcase
                end
            end
            S_SRD: begin
                if (l_reg <= r_reg) begin
                    ram_ctl.re = 1'b1;
                    raddr      = AW'(mid_w);
                    state_next = S_SCMP;
                end else begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
            end
            S_SCMP: begin
                if (key_reg < rdata) begin
                    r_next     = $signed(mid_w) - 1'b1;
                    state_next = S_SRD;
                end else if (key_reg > rdata) begin
                    l_next     = $signed(mid_w) + 1'b1;
                    state_next = S_SRD;
                end else begin
                    res_next.position = IDX_W'(mid_w);
                    if (op_reg == OP_REMOVE) begin
                        i_next     = CNT_W'(mid_w);
                        state_next = S_DRD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DRD: begin
                if (i_plus_w < {1'b0, count_reg}) begin
                    ram_ctl.re = 1'b1;
                    raddr      = AW'(i_plus_w);
                    state_next = S_DWR;
                end else begin
                    count_next           = count_reg - 1'b1;
                    res_next.entry_count = OCNT_W'(count_next);
                    state_next           = S_DONE;
                end
            end
            S_DWR: begin
                ram_ctl.we = 1'b1;
                waddr      = AW'(i_reg);
                wdata      = rdata;
                i_next     = CNT_W'(i_plus_w);
                state_next = S_DRD;
            end
            S_IRD: begin
                if (i_reg != '0) begin
                    ram_ctl.re = 1'b1;
                    raddr      = AW'(i_reg - 1'b1);
                    state_next = S_ICMP;
                end else begin
                    ram_ctl.we           = 1'b1;
                    count_next           = count_reg + 1'b1;
                    res_next.entry_count = OCNT_W'(count_next);
                    state_next           = S_DONE;
                end
            end
            S_ICMP: begin
                ram_ctl.we = 1'b1;
                waddr      = AW'(i_reg);
                if (rdata > key_reg) begin
                    wdata      = rdata;
                    i_next     = i_reg - 1'b1;
                    state_next = S_IRD;
                end else begin
                    count_next           = count_reg + 1'b1;
                    res_next.entry_count = OCNT_W'(count_next);
                    state_next           = S_DONE;
                end
            end
            S_RDAT: begin
                res_next.entry_value = rdata;
                state_next           = S_DONE;
            end
            S_DONE: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        op_reg  <= op_next;
        key_reg <= key_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        i_reg   <= i_next;
        res_reg <= res_next;
    end

endmodule

>>> src/sorted_table_search_update.sv
// Sorted table top level: engine plus output word register.
// Depends on sts_pkg, sts_engine.
// Keeps up to CAPACITY signed entries in ascending order in one table memory
// (one write, one registered read per cycle). One word in gives one word out.
// Each search step is a memory read followed by a compare. A lookup halves the
// search range on each step until it finds the key or the range is empty. Remove
// searches the same way, then moves each later entry down one place, a read and
// a write per entry; insert moves each larger entry up one place, a read and a
// compare-and-write per entry, then writes the key; read is a single registered
// memory read; an insert into a full table is refused with full status. A
// finished word waits in the output register while the next word in is accepted
// once the engine has handed it over.
module sorted_table_search_update #(
    parameter int CAPACITY = sts_pkg::DEFAULT_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sts_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sts_pkg::out_word_t  m_data
);
    import sts_pkg::*;

    logic      res_valid, res_take;
    out_word_t res_data;
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg;

    sts_engine #(.CAPACITY(CAPACITY)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_data  (res_data)
    );

    assign res_take     = res_valid && (!m_valid_reg || m_ready);
    assign m_valid_next = res_take ? 1'b1 : (m_valid_reg && !m_ready);
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_take) begin
            m_data_reg <= res_data;
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("engine idle right after accepting a word");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_FULL) |-> m_data.entry_count == OCNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    a_not_found_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_NOT_FOUND) |-> m_data.position == '0)
        else $error("nonzero position on not found");

    a_range_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_RANGE) |-> m_data.entry_value == '0)
        else $error("nonzero entry on index beyond count");

endmodule
